// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg: shared definitions for the rANS byte decoder
// Field widths, command and status codes, and default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

   localparam int SYMBOLS_DEF        = 256;
   localparam int PRECISION_BITS_DEF = 12;

   localparam int CMD_W  = 2;
   localparam int IDX_W  = 8;
   localparam int FREQ_W = 13;
   localparam int WORD_W = 32;
   localparam int BYTE_W = 8;
   localparam int STAT_W = 3;

   localparam logic [WORD_W-1:0] LOWER_BOUND = 32'h0080_0000;
   localparam logic [WORD_W-1:0] MIN_LENGTH  = 32'd4;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [FREQ_W-1:0] freq_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_STEP  = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_SYMBOL   = 3'd0,
      ST_BYTE     = 3'd1,
      ST_ACCEPTED = 3'd2,
      ST_ERROR    = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/rbd_if.sv =====
// ----------------------------------------------------------------------------
// rbd_if: request and response channels of the rANS byte decoder
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbd_req_if;
   logic                      valid;
   logic                      ready;
   logic [rbd_pkg::CMD_W-1:0] command;
   rbd_pkg::idx_type          symbol_index;
   rbd_pkg::freq_type         frequency;
   rbd_pkg::word_type         initial_state;
   rbd_pkg::word_type         payload_length;
   rbd_pkg::word_type         symbol_count;
   rbd_pkg::byte_type         payload_byte;

   modport source (
      output valid, command, symbol_index, frequency, initial_state,
             payload_length, symbol_count, payload_byte,
      input  ready
   );
   modport sink (
      input  valid, command, symbol_index, frequency, initial_state,
             payload_length, symbol_count, payload_byte,
      output ready
   );
endinterface

interface rbd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rbd_pkg::STAT_W-1:0] status;
   rbd_pkg::byte_type          symbol;
   logic                       last_symbol;

   modport source (
      output valid, status, symbol, last_symbol,
      input  ready
   );
   modport sink (
      input  valid, status, symbol, last_symbol,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/rans_byte_decoder.sv =====
// ----------------------------------------------------------------------------
// rans_byte_decoder: rANS stream decoder, byte alphabet, byte renormalization
//
// Request channel (req_bus) carries one command per transaction: load a
// frequency, start a frame, or step with one offered payload byte. Every
// request yields exactly one response transaction (status, symbol, last).
// Load, step that takes a byte, step with nothing left and unknown commands
// respond through the result register and then the response register; with
// the response side open such requests are taken every cycle. A step that
// decodes a symbol goes through a reverse table read, a frequency/cumulative
// read, a multiply and a state update. A start sweeps the frequency memory to
// check the sum and the payload length, then writes the cumulative memory and
// fills the reverse memory one entry per cycle when the check passes; when it
// fails, the start answers with an error.
// Reset clears the frequency table (per-entry valid bits), the coder state
// and the frame counters; it needs no clearing pass. When the receiver
// stalls, the response register holds and one more request may be taken; it
// then waits for the register to free before answering.
// ----------------------------------------------------------------------------
`default_nettype none

module rans_byte_decoder #(
   parameter int SYMBOLS        = rbd_pkg::SYMBOLS_DEF,
   parameter int PRECISION_BITS = rbd_pkg::PRECISION_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   rbd_req_if.sink      req_bus,
   rbd_rsp_if.source    rsp_bus
);

   localparam int IdxW   = $clog2(SYMBOLS);
   localparam int Pb     = PRECISION_BITS;
   localparam int Total  = 1 << PRECISION_BITS;
   localparam int CumW   = PRECISION_BITS + 1;
   localparam int SumW   = rbd_pkg::FREQ_W + $clog2(SYMBOLS) + 3;
   localparam int WordW  = rbd_pkg::WORD_W;
   localparam int ByteW  = rbd_pkg::BYTE_W;
   localparam int FreqW  = rbd_pkg::FREQ_W;

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_EMIT    = 12'b0000_0000_0010,
      S_SUM     = 12'b0000_0000_0100,
      S_SUMLAST = 12'b0000_0000_1000,
      S_CHECK   = 12'b0000_0001_0000,
      S_BRD     = 12'b0000_0010_0000,
      S_BCUM    = 12'b0000_0100_0000,
      S_BFILL   = 12'b0000_1000_0000,
      S_OPEN    = 12'b0001_0000_0000,
      S_DEC1    = 12'b0010_0000_0000,
      S_DEC2    = 12'b0100_0000_0000,
      S_DEC3    = 12'b1000_0000_0000
   } state_type;

   // memories
   logic [FreqW-1:0] freq_mem [SYMBOLS];
   logic [CumW-1:0]  cum_mem  [SYMBOLS];
   logic [IdxW-1:0]  rev_mem  [Total];
   logic [SYMBOLS-1:0] freq_vld_ff, freq_vld_in;

   logic [FreqW-1:0] freq_rd_ff;
   logic             vld_rd_ff;
   logic [CumW-1:0]  cum_rd_ff;
   logic [IdxW-1:0]  rev_rd_ff;

   // control and datapath registers
   state_type             st_ff, st_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rbd_pkg::word_type     coder_state_ff, coder_state_in;
   rbd_pkg::word_type     bytes_left_ff, bytes_left_in;
   rbd_pkg::word_type     symbols_left_ff, symbols_left_in;
   logic                  first_ff, first_in;

   logic [IdxW-1:0]       cnt_ff, cnt_in;
   logic [SumW-1:0]       sum_ff, sum_in;
   logic [CumW-1:0]       run_ff, run_in;
   logic [FreqW-1:0]      rem_ff, rem_in;
   logic [IdxW-1:0]       sym_ff, sym_in;
   rbd_pkg::word_type     prod_ff, prod_in;
   rbd_pkg::word_type     start_state_ff, start_state_in;
   rbd_pkg::word_type     start_len_ff, start_len_in;
   rbd_pkg::word_type     start_count_ff, start_count_in;

   rbd_pkg::status_type   res_status_ff, res_status_in;
   logic [ByteW-1:0]      res_symbol_ff, res_symbol_in;
   logic                  res_last_ff, res_last_in;
   rbd_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [ByteW-1:0]      rsp_symbol_ff, rsp_symbol_in;
   logic                  rsp_last_ff, rsp_last_in;

   // memory port controls
   logic             freq_we, freq_re, cum_we, cum_re, rev_we;
   logic [IdxW-1:0]  freq_wa, freq_ra;
   logic [FreqW-1:0] freq_wd;

   logic             out_free;
   logic             ready;
   logic             acc;
   logic [FreqW-1:0] fq;
   logic [Pb-1:0]    slot;
   logic             cnt_last;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign ready    = (st_ff == S_IDLE) || ((st_ff == S_EMIT) && out_free);
   assign acc      = req_bus.valid && ready;
   assign fq       = vld_rd_ff ? freq_rd_ff : '0;
   assign slot     = coder_state_ff[Pb-1:0];
   assign cnt_last = (cnt_ff == IdxW'(SYMBOLS - 1));

   always_comb begin
      st_in           = st_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      coder_state_in  = coder_state_ff;
      bytes_left_in   = bytes_left_ff;
      symbols_left_in = symbols_left_ff;
      first_in        = first_ff;
      freq_vld_in     = freq_vld_ff;
      cnt_in          = cnt_ff;
      sum_in          = sum_ff;
      run_in          = run_ff;
      rem_in          = rem_ff;
      sym_in          = sym_ff;
      prod_in         = prod_ff;
      start_state_in  = start_state_ff;
      start_len_in    = start_len_ff;
      start_count_in  = start_count_ff;
      res_status_in   = res_status_ff;
      res_symbol_in   = res_symbol_ff;
      res_last_in     = res_last_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_symbol_in   = rsp_symbol_ff;
      rsp_last_in     = rsp_last_ff;
      freq_we         = 1'b0;
      freq_wa         = req_bus.symbol_index[IdxW-1:0];
      freq_wd         = req_bus.frequency;
      freq_re         = 1'b0;
      freq_ra         = cnt_ff;
      cum_we          = 1'b0;
      cum_re          = 1'b0;
      rev_we          = 1'b0;

      case (st_ff)
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_symbol_in = res_symbol_ff;
               rsp_last_in   = res_last_ff;
               st_in         = S_IDLE;
            end
         end
         S_SUM: begin
            // the registered read returns data of the previous address
            if (cnt_ff != '0) begin
               sum_in = sum_ff + SumW'(fq);
            end
            freq_re = 1'b1;
            if (cnt_last) begin
               st_in = S_SUMLAST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SUMLAST: begin
            sum_in = sum_ff + SumW'(fq);
            st_in  = S_CHECK;
         end
         S_CHECK: begin
            if ((start_len_ff < rbd_pkg::MIN_LENGTH) || (sum_ff != SumW'(Total))) begin
               symbols_left_in = '0;
               bytes_left_in   = '0;
               first_in        = 1'b0;
               res_status_in   = rbd_pkg::ST_ERROR;
               res_symbol_in   = '0;
               res_last_in     = 1'b0;
               st_in           = S_EMIT;
            end else begin
               cnt_in = '0;
               run_in = '0;
               st_in  = S_BRD;
            end
         end
         S_BRD: begin
            freq_re = 1'b1;
            st_in   = S_BCUM;
         end
         S_BCUM: begin
            cum_we = 1'b1;
            rem_in = fq;
            if (fq != '0) begin
               st_in = S_BFILL;
            end else if (cnt_last) begin
               st_in = S_OPEN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               st_in  = S_BRD;
            end
         end
         S_BFILL: begin
            rev_we = 1'b1;
            run_in = run_ff + 1'b1;
            rem_in = rem_ff - 1'b1;
            if (rem_ff == FreqW'(1)) begin
               if (cnt_last) begin
                  st_in = S_OPEN;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  st_in  = S_BRD;
               end
            end
         end
         S_OPEN: begin
            coder_state_in  = start_state_ff;
            bytes_left_in   = start_len_ff - rbd_pkg::MIN_LENGTH;
            symbols_left_in = start_count_ff;
            first_in        = 1'b1;
            res_status_in   = rbd_pkg::ST_ACCEPTED;
            res_symbol_in   = '0;
            res_last_in     = 1'b0;
            st_in           = S_EMIT;
         end
         S_DEC1: begin
            // reverse lookup is ready; fetch frequency and cumulative
            freq_re = 1'b1;
            freq_ra = rev_rd_ff;
            cum_re  = 1'b1;
            sym_in  = rev_rd_ff;
            st_in   = S_DEC2;
         end
         S_DEC2: begin
            prod_in = WordW'(fq) * (coder_state_ff >> Pb);
            st_in   = S_DEC3;
         end
         S_DEC3: begin
            coder_state_in  = prod_ff + WordW'(slot) - WordW'(cum_rd_ff);
            symbols_left_in = symbols_left_ff - 1'b1;
            first_in        = 1'b0;
            res_status_in   = rbd_pkg::ST_SYMBOL;
            res_symbol_in   = ByteW'(sym_ff);
            res_last_in     = (symbols_left_ff == WordW'(1));
            st_in           = S_EMIT;
         end
         default: begin
         end
      endcase

      if (acc) begin
         res_symbol_in = '0;
         res_last_in   = 1'b0;
         st_in         = S_EMIT;
         case (req_bus.command)
            rbd_pkg::CMD_LOAD: begin
               if ({1'b0, req_bus.symbol_index} >= (rbd_pkg::IDX_W + 1)'(SYMBOLS)) begin
                  res_status_in = rbd_pkg::ST_ERROR;
               end else begin
                  freq_we                  = 1'b1;
                  freq_vld_in[freq_wa]     = 1'b1;
                  res_status_in            = rbd_pkg::ST_ACCEPTED;
               end
            end
            rbd_pkg::CMD_START: begin
               start_state_in = req_bus.initial_state;
               start_len_in   = req_bus.payload_length;
               start_count_in = req_bus.symbol_count;
               sum_in         = '0;
               cnt_in         = '0;
               st_in          = S_SUM;
            end
            rbd_pkg::CMD_STEP: begin
               if (symbols_left_ff == '0) begin
                  res_status_in = rbd_pkg::ST_EMPTY;
               end else if (!first_ff && (coder_state_ff < rbd_pkg::LOWER_BOUND) &&
                            (bytes_left_ff != '0)) begin
                  coder_state_in = {coder_state_ff[WordW-ByteW-1:0], req_bus.payload_byte};
                  bytes_left_in  = bytes_left_ff - 1'b1;
                  res_status_in  = rbd_pkg::ST_BYTE;
               end else begin
                  st_in = S_DEC1;
               end
            end
            default: begin
               res_status_in = rbd_pkg::ST_ERROR;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff           <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         coder_state_ff  <= '0;
         bytes_left_ff   <= '0;
         symbols_left_ff <= '0;
         first_ff        <= 1'b0;
         freq_vld_ff     <= '0;
      end else begin
         st_ff           <= st_in;
         rsp_valid_ff    <= rsp_valid_in;
         coder_state_ff  <= coder_state_in;
         bytes_left_ff   <= bytes_left_in;
         symbols_left_ff <= symbols_left_in;
         first_ff        <= first_in;
         freq_vld_ff     <= freq_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      sum_ff         <= sum_in;
      run_ff         <= run_in;
      rem_ff         <= rem_in;
      sym_ff         <= sym_in;
      prod_ff        <= prod_in;
      start_state_ff <= start_state_in;
      start_len_ff   <= start_len_in;
      start_count_ff <= start_count_in;
      res_status_ff  <= res_status_in;
      res_symbol_ff  <= res_symbol_in;
      res_last_ff    <= res_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_symbol_ff  <= rsp_symbol_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // frequency memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (freq_we) begin
         freq_mem[freq_wa] <= freq_wd;
      end
      if (freq_re) begin
         freq_rd_ff <= freq_mem[freq_ra];
         vld_rd_ff  <= freq_vld_ff[freq_ra];
      end
   end

   // cumulative memory
   always_ff @(posedge clock) begin
      if (cum_we) begin
         cum_mem[cnt_ff] <= run_ff;
      end
      if (cum_re) begin
         cum_rd_ff <= cum_mem[rev_rd_ff];
      end
   end

   // reverse memory: read the slot of the current state every cycle
   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[run_ff[Pb-1:0]] <= cnt_ff;
      end
      rev_rd_ff <= rev_mem[slot];
   end

   assign req_bus.ready       = ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.symbol      = rsp_symbol_ff;
   assign rsp_bus.last_symbol = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/rbd_checker.sv =====
// ----------------------------------------------------------------------------
// rbd_checker: port-level checks for the rANS byte decoder
// Response channel hold rules, payload cleanliness and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire [rbd_pkg::STAT_W-1:0] rsp_status,
   input wire [rbd_pkg::BYTE_W-1:0] rsp_symbol,
   input wire                       rsp_last
);

   // stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // stalled response payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_status) && $stable(rsp_symbol) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   // only a decoded symbol carries a symbol or the last flag
   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rbd_pkg::ST_SYMBOL) |->
         (rsp_symbol == '0) && !rsp_last)
      else $error("non-symbol response carries symbol data");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rans_byte_decoder rbd_checker u_rbd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_symbol (rsp_bus.symbol),
   .rsp_last   (rsp_bus.last_symbol)
);

`default_nettype wire

// ===== verif/tb_rans_byte_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_rans_byte_decoder: self-checking testbench for the rANS byte decoder
// Drives load, start and step transactions and predicts every response with
// a cycle-free model of the tables, coder state and frame counters. Runs a
// short directed pass and then random frames under several idle and stall
// mixes, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rans_byte_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PROB_TOTAL = 1 << rbd_pkg::PRECISION_BITS_DEF;
   localparam int unsigned PROB_MASK  = PROB_TOTAL - 1;
   localparam logic [rbd_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int DRAIN_CYCLES    = 32;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RESET_CYCLES    = 6;
   localparam int MAX_FRAME_STEPS = 80;

   typedef struct {
      logic [rbd_pkg::CMD_W-1:0] command;
      rbd_pkg::idx_type          symbol_index;
      rbd_pkg::freq_type         frequency;
      rbd_pkg::word_type         initial_state;
      rbd_pkg::word_type         payload_length;
      rbd_pkg::word_type         symbol_count;
      rbd_pkg::byte_type         payload_byte;
   } dec_request_type;

   typedef struct {
      rbd_pkg::status_type status;
      rbd_pkg::byte_type   symbol;
      logic                last_symbol;
   } dec_response_type;

   logic clock;
   logic reset;

   rbd_req_if req_bus ();
   rbd_rsp_if rsp_bus ();

   rans_byte_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // decoder shadow state
   rbd_pkg::freq_type freq_mem [rbd_pkg::SYMBOLS_DEF];
   rbd_pkg::freq_type cum_mem [rbd_pkg::SYMBOLS_DEF];
   rbd_pkg::idx_type  slot_to_symbol [PROB_TOTAL];
   rbd_pkg::word_type coder_state;
   rbd_pkg::word_type bytes_left;
   rbd_pkg::word_type symbols_left;
   logic              first_pending;

   dec_response_type awaited_responses [$];

   int errors        = 0;
   int work_items    = 0;
   int cycle_count   = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_left     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: long hold-off first, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready = ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      dec_response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected response: status=%0d symbol=%0d last=%0d",
                     $time, rsp_bus.status, rsp_bus.symbol, rsp_bus.last_symbol);
            errors++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.symbol !== want.symbol ||
                rsp_bus.last_symbol !== want.last_symbol) begin
               $display("%0t: response mismatch: expected status=%0d symbol=%0d last=%0d,",
                        $time, want.status, want.symbol, want.last_symbol);
               $display("   actual status=%0d symbol=%0d last=%0d",
                        rsp_bus.status, rsp_bus.symbol, rsp_bus.last_symbol);
               errors++;
            end
         end
      end
   end

   function automatic dec_response_type advance_decoder(dec_request_type it);
      dec_response_type  r;
      int unsigned       total;
      rbd_pkg::word_type slot;
      rbd_pkg::word_type freq_w;
      rbd_pkg::word_type cum_w;
      rbd_pkg::idx_type  sym;
      r.status      = rbd_pkg::ST_ERROR;
      r.symbol      = '0;
      r.last_symbol = 1'b0;
      case (it.command)
         rbd_pkg::CMD_LOAD: begin
            freq_mem[it.symbol_index] = it.frequency;
            r.status = rbd_pkg::ST_ACCEPTED;
         end
         rbd_pkg::CMD_START: begin
            total = 0;
            foreach (freq_mem[s]) total += freq_mem[s];
            if (it.payload_length < rbd_pkg::MIN_LENGTH || total != PROB_TOTAL) begin
               // close any open frame, tables untouched
               symbols_left  = '0;
               bytes_left    = '0;
               first_pending = 1'b0;
            end else begin
               total = 0;
               for (int s = 0; s < rbd_pkg::SYMBOLS_DEF; s++) begin
                  cum_mem[s] = total[rbd_pkg::FREQ_W-1:0];
                  for (int unsigned j = total; j < total + freq_mem[s]; j++)
                     slot_to_symbol[j & PROB_MASK] = rbd_pkg::idx_type'(s);
                  total += freq_mem[s];
               end
               coder_state   = it.initial_state;
               bytes_left    = it.payload_length - rbd_pkg::MIN_LENGTH;
               symbols_left  = it.symbol_count;
               first_pending = 1'b1;
               r.status      = rbd_pkg::ST_ACCEPTED;
            end
         end
         rbd_pkg::CMD_STEP: begin
            if (symbols_left == 0) begin
               r.status = rbd_pkg::ST_EMPTY;
            end else if (!first_pending && coder_state < rbd_pkg::LOWER_BOUND &&
                         bytes_left != 0) begin
               coder_state = (coder_state << rbd_pkg::BYTE_W) |
                             rbd_pkg::word_type'(it.payload_byte);
               bytes_left--;
               r.status = rbd_pkg::ST_BYTE;
            end else begin
               slot   = coder_state & PROB_MASK;
               sym    = slot_to_symbol[slot];
               freq_w = rbd_pkg::word_type'(freq_mem[sym]);
               cum_w  = rbd_pkg::word_type'(cum_mem[sym]);
               coder_state = freq_w * (coder_state >> rbd_pkg::PRECISION_BITS_DEF) +
                             slot - cum_w;
               symbols_left--;
               first_pending = 1'b0;
               r.status      = rbd_pkg::ST_SYMBOL;
               r.symbol      = sym;
               r.last_symbol = (symbols_left == 0);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // random filler in every field the command does not use
   function automatic dec_request_type noise_request();
      dec_request_type r;
      r.command        = CMD_UNKNOWN;
      r.symbol_index   = rbd_pkg::idx_type'($urandom);
      r.frequency      = rbd_pkg::freq_type'($urandom);
      r.initial_state  = $urandom;
      r.payload_length = $urandom;
      r.symbol_count   = $urandom;
      r.payload_byte   = rbd_pkg::byte_type'($urandom);
      return r;
   endfunction

   function automatic dec_request_type load_request(rbd_pkg::idx_type idx,
                                                    rbd_pkg::freq_type freq);
      dec_request_type r;
      r = noise_request();
      r.command      = rbd_pkg::CMD_LOAD;
      r.symbol_index = idx;
      r.frequency    = freq;
      return r;
   endfunction

   function automatic dec_request_type start_request(rbd_pkg::word_type state,
                                                     rbd_pkg::word_type length,
                                                     rbd_pkg::word_type count);
      dec_request_type r;
      r = noise_request();
      r.command        = rbd_pkg::CMD_START;
      r.initial_state  = state;
      r.payload_length = length;
      r.symbol_count   = count;
      return r;
   endfunction

   function automatic dec_request_type step_request(rbd_pkg::byte_type data);
      dec_request_type r;
      r = noise_request();
      r.command      = rbd_pkg::CMD_STEP;
      r.payload_byte = data;
      return r;
   endfunction

   task automatic send_item(dec_request_type it);
      dec_response_type want;
      @(negedge clock);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.command        = it.command;
      req_bus.symbol_index   = it.symbol_index;
      req_bus.frequency      = it.frequency;
      req_bus.initial_state  = it.initial_state;
      req_bus.payload_length = it.payload_length;
      req_bus.symbol_count   = it.symbol_count;
      req_bus.payload_byte   = it.payload_byte;
      req_bus.valid          = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      want = advance_decoder(it);
      awaited_responses.push_back(want);
      if (it.command != CMD_UNKNOWN && want.status != rbd_pkg::ST_EMPTY)
         work_items++;
   endtask

   // drop valid and hold until every response is in; returns on a rising edge
   task automatic wait_drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      do @(posedge clock); while (awaited_responses.size() != 0);
   endtask

   // load a fresh table summing to the total, touching only changed entries
   task automatic program_distribution(int unsigned spread);
      rbd_pkg::freq_type target [rbd_pkg::SYMBOLS_DEF];
      int unsigned       remaining;
      int unsigned       share;
      rbd_pkg::idx_type  pick;
      foreach (target[s]) target[s] = '0;
      remaining = PROB_TOTAL;
      for (int i = 0; i < spread; i++) begin
         pick = rbd_pkg::idx_type'($urandom);
         share = (i == spread - 1) ? remaining : $urandom_range(remaining, 0);
         target[pick] = target[pick] + rbd_pkg::freq_type'(share);
         remaining -= share;
      end
      for (int s = 0; s < rbd_pkg::SYMBOLS_DEF; s++)
         if (freq_mem[s] != target[s])
            send_item(load_request(rbd_pkg::idx_type'(s), target[s]));
   endtask

   task automatic run_random_frame();
      int unsigned       pick;
      int unsigned       spread;
      int unsigned       steps;
      rbd_pkg::word_type state;
      rbd_pkg::word_type length;
      rbd_pkg::word_type count;
      pick = $urandom_range(99, 0);
      spread = (pick < 10) ? 1 : (pick < 20) ? $urandom_range(64, 9) : $urandom_range(8, 2);
      program_distribution(spread);
      // now and then overwrite one entry at random, which mostly breaks the sum for the start check
      if ($urandom_range(99, 0) < 10)
         send_item(load_request(rbd_pkg::idx_type'($urandom),
                                rbd_pkg::freq_type'($urandom_range(8191, 0))));

      pick = $urandom_range(99, 0);
      state = (pick < 10) ? '0 : (pick < 20) ? '1 :
              (pick < 70) ? ($urandom | rbd_pkg::LOWER_BOUND) : $urandom;
      pick = $urandom_range(99, 0);
      length = (pick < 75) ? rbd_pkg::MIN_LENGTH + $urandom_range(24, 0) :
               (pick < 88) ? $urandom : $urandom_range(3, 0);
      pick = $urandom_range(99, 0);
      count = (pick < 80) ? $urandom_range(30, 1) : (pick < 88) ? '0 : $urandom;
      send_item(start_request(state, length, count));

      steps = 0;
      while (symbols_left != 0 && steps < MAX_FRAME_STEPS) begin
         pick = $urandom_range(99, 0);
         if (pick < 4)
            send_item(load_request(rbd_pkg::idx_type'($urandom),
                                   rbd_pkg::freq_type'($urandom_range(PROB_TOTAL, 0))));
         else if (pick < 7)
            send_item(noise_request());
         else
            send_item(step_request(rbd_pkg::byte_type'($urandom)));
         steps++;
      end
      if ($urandom_range(99, 0) < 30)
         send_item(step_request(rbd_pkg::byte_type'($urandom)));
   endtask

   task automatic test_directed_cases();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_item(step_request(8'h5A));              // nothing left after reset
      send_item(noise_request());                  // unknown command
      send_item(start_request(32'h1234_5678, 32'd10, 32'd5));   // empty table
      // single symbol owns the range
      send_item(load_request(8'hFF, rbd_pkg::freq_type'(PROB_TOTAL)));
      send_item(start_request(32'h1234_5678, 32'd3, 32'd2));    // length too short
      send_item(start_request('1, rbd_pkg::MIN_LENGTH, 32'd2));
      send_item(step_request(8'hAB));
      send_item(step_request(8'h00));
      send_item(step_request(8'hFF));
      send_item(load_request(8'hFF, '1));          // above the total
      send_item(start_request('1, 32'd8, 32'd1));
      send_item(load_request(8'hFF, '0));
      send_item(load_request(8'h00, rbd_pkg::freq_type'(PROB_TOTAL / 2)));
      send_item(load_request(8'hAA, rbd_pkg::freq_type'(PROB_TOTAL / 2)));
      send_item(start_request('0, '1, '0));        // zero symbols
      send_item(step_request(8'h11));
      send_item(start_request('0, 32'd6, 32'd4));  // payload runs out mid-frame
      send_item(step_request(8'hFF));
      send_item(load_request(8'hAA, 13'd100));     // frequency changes mid-frame
      while (symbols_left != 0)
         send_item(step_request(8'hFF));
      send_item(step_request(8'h22));
      wait_drain();
   endtask

   task automatic test_random_frames(int idle_pct, int stall_pct, int goal);
      int target;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      target = work_items + goal;
      while (work_items < target)
         run_random_frame();
      wait_drain();
   endtask

   task automatic test_receiver_hold_off();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      program_distribution(4);
      send_item(start_request($urandom | rbd_pkg::LOWER_BOUND, 32'd200, 32'd60));
      wait_drain();
      // keep offering steps while the receiver is shut
      hold_left = HOLD_OFF_CYCLES;
      repeat (40) send_item(step_request(rbd_pkg::byte_type'($urandom)));
      wait_drain();
   endtask

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.command        = rbd_pkg::CMD_LOAD;
      req_bus.symbol_index   = '0;
      req_bus.frequency      = '0;
      req_bus.initial_state  = '0;
      req_bus.payload_length = '0;
      req_bus.symbol_count   = '0;
      req_bus.payload_byte   = '0;
      rsp_bus.ready          = 1'b0;
      foreach (freq_mem[s]) begin
         freq_mem[s] = '0;
         cum_mem[s]  = '0;
      end
      foreach (slot_to_symbol[j]) slot_to_symbol[j] = '0;
      coder_state   = '0;
      bytes_left    = '0;
      symbols_left  = '0;
      first_pending = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_frames(0, 0, 450);
      test_random_frames(67, 0, 450);
      test_random_frames(0, 67, 450);
      test_random_frames(28, 28, 450);
      test_receiver_hold_off();

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/rbd_pkg.sv
rtl/rbd_if.sv
rtl/rans_byte_decoder.sv
rtl/rbd_checker.sv
verif/tb_rans_byte_decoder.sv
